[rtl/bmc_pkg.sv]
// ----------------------------------------------------------------------------
// bmc_pkg: shared types and constants of the bracket match checker
// Beat payloads, result codes, bracket kinds and the byte decoder.
// ----------------------------------------------------------------------------
package bmc_pkg;

  // Stack size and position counter width
  localparam int STACK_DEPTH   = 64;
  localparam int POSITION_BITS = 16;
  localparam int DEPTH_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int OUT_POS_W     = 16;

  // Bracket characters
  localparam logic [7:0] CH_ROUND_OPEN   = 8'h28;  // (
  localparam logic [7:0] CH_ROUND_CLOSE  = 8'h29;  // )
  localparam logic [7:0] CH_SQUARE_OPEN  = 8'h5B;  // [
  localparam logic [7:0] CH_SQUARE_CLOSE = 8'h5D;  // ]
  localparam logic [7:0] CH_CURLY_OPEN   = 8'h7B;  // {
  localparam logic [7:0] CH_CURLY_CLOSE  = 8'h7D;  // }

  typedef enum logic [1:0] {
    KIND_ROUND  = 2'd0,
    KIND_SQUARE = 2'd1,
    KIND_CURLY  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    VERDICT_NONE     = 2'd0,
    VERDICT_BALANCED = 2'd1,
    VERDICT_FAILED   = 2'd2
  } verdict_t;

  // Input beat
  typedef struct packed {
    logic [7:0] symbol;
    logic       is_last;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic [1:0]           status;
    logic [OUT_POS_W-1:0] open_position;
    logic [OUT_POS_W-1:0] close_position;
    logic [1:0]           verdict;
  } out_beat_t;

  // One stack entry
  typedef struct packed {
    kind_t                    kind;
    logic [POSITION_BITS-1:0] pos;
  } stk_entry_t;

  // Decoded byte
  typedef struct packed {
    logic  is_open;
    logic  is_close;
    kind_t kind;
  } sym_class_t;

  // Classify one byte as open bracket, close bracket or other
  function automatic sym_class_t classify(input logic [7:0] sym);
    sym_class_t c;
    c.is_open  = 1'b0;
    c.is_close = 1'b0;
    c.kind     = KIND_ROUND;
    unique case (sym)
      CH_ROUND_OPEN: begin
        c.is_open = 1'b1;
        c.kind    = KIND_ROUND;
      end
      CH_SQUARE_OPEN: begin
        c.is_open = 1'b1;
        c.kind    = KIND_SQUARE;
      end
      CH_CURLY_OPEN: begin
        c.is_open = 1'b1;
        c.kind    = KIND_CURLY;
      end
      CH_ROUND_CLOSE: begin
        c.is_close = 1'b1;
        c.kind     = KIND_ROUND;
      end
      CH_SQUARE_CLOSE: begin
        c.is_close = 1'b1;
        c.kind     = KIND_SQUARE;
      end
      CH_CURLY_CLOSE: begin
        c.is_close = 1'b1;
        c.kind     = KIND_CURLY;
      end
      default: begin
        c.is_open = 1'b0;
      end
    endcase
    return c;
  endfunction

endpackage

[rtl/bracket_match_checker_unit.sv]
// ----------------------------------------------------------------------------
// bracket_match_checker_unit: streaming check of ( ) [ ] { } nesting
// One byte per beat in, one status beat out per byte, verdict on last byte.
// ----------------------------------------------------------------------------
// Usage: the block takes one byte per clock and returns one result beat per
// byte. A byte passes through the input register and then the result
// register before its result beat turns valid on the output.
// Throughput is one byte per cycle; it drops only while the result side
// stalls. Open brackets go onto a stack memory of STACK_DEPTH entries; the
// top entry is read from that memory ahead of use into a register (with
// a forward of the entry just pushed), which is what lets a pop follow a
// push in the next cycle. Stack contents need no clearing after reset, so
// the block is ready as soon as reset is released. The beat that carries
// is_last gives the verdict and returns the depth, position and error flag
// to zero for the next string.
module bracket_match_checker_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bmc_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bmc_pkg::out_beat_t out_data
);

  localparam int AW = bmc_pkg::ADDR_W;
  localparam int DW = bmc_pkg::DEPTH_W;
  localparam int PW = bmc_pkg::POSITION_BITS;
  localparam int OW = bmc_pkg::OUT_POS_W;

  // Input stage
  logic               in_valid_r;
  bmc_pkg::in_beat_t  in_r;
  // Result stage
  logic               out_valid_r;
  bmc_pkg::out_beat_t out_r, out_nxt;
  // Checker state
  logic [DW-1:0]      depth_r, depth_nxt, depth_op;
  logic [PW-1:0]      pos_r, pos_nxt;
  logic               err_r, err_nxt, err_op;
  // Stack memory and its registered top
  bmc_pkg::stk_entry_t stack_mem [bmc_pkg::STACK_DEPTH];
  bmc_pkg::stk_entry_t top_r;
  bmc_pkg::stk_entry_t push_entry;
  logic [DW-1:0]       rd_depth;
  logic [DW-1:0]       rd_index;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;

  logic                proc;
  logic                push_ok;
  logic                pop_ok;
  bmc_pkg::sym_class_t cls;
  bmc_pkg::status_t    status;
  logic [PW-1:0]       open_pos;
  logic                stack_full;
  logic                stack_empty;

  // Advance the input stage whenever the result stage can take a beat
  assign proc     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || proc;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Decide push, pop or error for the byte in the input stage
  assign cls         = bmc_pkg::classify(in_r.symbol);
  assign stack_full  = (depth_r == DW'(bmc_pkg::STACK_DEPTH));
  assign stack_empty = (depth_r == '0);

  always_comb begin
    status   = bmc_pkg::ST_OK;
    open_pos = '0;
    push_ok  = 1'b0;
    pop_ok   = 1'b0;
    priority if (cls.is_open) begin
      if (stack_full) begin
        status = bmc_pkg::ST_OVERFLOW;
      end else begin
        push_ok = 1'b1;
      end
    end else if (cls.is_close) begin
      priority if (stack_empty) begin
        status = bmc_pkg::ST_EMPTY;
      end else if (top_r.kind == cls.kind) begin
        pop_ok = 1'b1;
      end else begin
        status   = bmc_pkg::ST_MISMATCH;
        open_pos = top_r.pos;
      end
    end else begin
      status = bmc_pkg::ST_OK;
    end
  end

  // Form next state and the result beat
  always_comb begin
    depth_op = depth_r;
    if (push_ok) begin
      depth_op = depth_r + DW'(1);
    end else if (pop_ok) begin
      depth_op = depth_r - DW'(1);
    end
    err_op = err_r || (status != bmc_pkg::ST_OK);

    out_nxt.status         = status;
    out_nxt.open_position  = OW'(open_pos);
    out_nxt.close_position = OW'(pos_r);
    out_nxt.verdict        = bmc_pkg::VERDICT_NONE;

    depth_nxt = depth_r;
    pos_nxt   = pos_r;
    err_nxt   = err_r;
    if (proc) begin
      if (in_r.is_last) begin
        out_nxt.verdict = (!err_op && depth_op == '0) ? bmc_pkg::VERDICT_BALANCED
                                                       : bmc_pkg::VERDICT_FAILED;
        depth_nxt = '0;
        pos_nxt   = '0;
        err_nxt   = 1'b0;
      end else begin
        depth_nxt = depth_op;
        pos_nxt   = (pos_r != {PW{1'b1}}) ? pos_r + PW'(1) : pos_r;
        err_nxt   = err_op;
      end
    end
  end

  // Stack addressing: write at the current depth, read the next top
  assign push_entry.kind = cls.kind;
  assign push_entry.pos  = pos_r;
  assign wr_addr  = depth_r[AW-1:0];
  assign rd_depth = proc ? depth_op : depth_r;
  assign rd_index = rd_depth - DW'(1);
  assign rd_addr  = rd_index[AW-1:0];

  // Write pushed entries; refresh top, forwarding a fresh push
  always_ff @(posedge clk) begin
    if (proc && push_ok) begin
      stack_mem[wr_addr] <= push_entry;
    end
    if (proc && push_ok) begin
      top_r <= push_entry;
    end else begin
      top_r <= stack_mem[rd_addr];
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      depth_r     <= '0;
      pos_r       <= '0;
      err_r       <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (proc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      depth_r <= depth_nxt;
      pos_r   <= pos_nxt;
      err_r   <= err_nxt;
    end
  end

  // Load payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (proc) begin
      out_r <= out_nxt;
    end
  end

  // Depth never passes the stack size
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(bmc_pkg::STACK_DEPTH))
    else $error("stack depth beyond capacity");

  // The last byte of a string leaves the checker cleared
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    proc && in_r.is_last |=> depth_r == '0 && pos_r == '0 && !err_r)
    else $error("checker not cleared after last byte");

  // A balanced verdict cannot come with an error on the same beat
  a_balanced_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.verdict == bmc_pkg::VERDICT_BALANCED
      |-> out_r.status == bmc_pkg::ST_OK)
    else $error("balanced verdict with error status");

  // Open position is reported only for a kind mismatch
  a_open_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status != bmc_pkg::ST_MISMATCH |-> out_r.open_position == '0)
    else $error("open position outside mismatch");

  // Input stalls only when both stages are full and the output is blocked
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_valid_r && out_valid_r && !out_ready)
    else $error("input stalled without backpressure");

endmodule
